// ----- sv/bsg_pkg.sv -----
package bsg_pkg;

  localparam int PIX_W   = 16;
  localparam int COORD_W = 19;
  localparam int GRAD_W  = 17;
  localparam int IDX_W   = 9;
  localparam int CFG_W   = 10;

  localparam int COL_LSB = 0;
  localparam int ROW_LSB = COL_LSB + IDX_W;
  localparam int VAL_LSB = ROW_LSB + IDX_W;
  localparam int U_LSB   = VAL_LSB + PIX_W;
  localparam int V_LSB   = U_LSB + COORD_W;
  localparam int IN_FIELDS_W = V_LSB + COORD_W;
  localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;

  localparam int INT_LSB   = 0;
  localparam int GU_LSB    = INT_LSB + PIX_W;
  localparam int GV_LSB    = GU_LSB + GRAD_W;
  localparam int OUT_FIELDS_W = GV_LSB + GRAD_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;
  localparam int OUT_USER_W   = 2;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;
  localparam logic [CFG_W-1:0]     IMG_DIM_RST      = 10'd512;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

endpackage

// ----- sv/bilinear_sample_and_gradient_unit.sv -----
// Bilinear sampler with analytic gradient over an on-chip grayscale image. A write request
// stores one Q8.8 pixel and gives no result; a sample request returns the interpolated
// Q8.8 intensity and dI/du, dI/dv in signed Q9.8. One request is taken every cycle while
// the output is not stalled; a stall on the output backs up through the three stages to
// in_tready. The pixel store is four banks interleaved by row and column parity, so the
// four neighbours come out of one synchronous read per bank in the same cycle. The store
// is not cleared: a pixel read before it was ever written gives an undefined result.
// Writes outside MAX_WIDTH x MAX_HEIGHT are dropped.
module bilinear_sample_and_gradient_unit #(
  parameter int MAX_WIDTH     = 512,
  parameter int MAX_HEIGHT    = 512,
  parameter int FRACTION_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // pixel_col[8:0], pixel_row[17:9], pixel_value[33:18], sample_u[52:34], sample_v[71:53]
  input  logic [bsg_pkg::IN_DATA_W-1:0]       in_tdata,
  // operation[0]
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // intensity[15:0], grad_u[32:16], grad_v[49:33], zero pad[55:50]
  output logic [bsg_pkg::OUT_DATA_W-1:0]      out_tdata,
  // intensity_inside[0], gradient_inside[1]
  output logic [bsg_pkg::OUT_USER_W-1:0]      out_tuser,
  input  logic                                cfg_we,
  input  logic [bsg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bsg_pkg::CFG_W-1:0]           cfg_wdata
);
  import bsg_pkg::*;

  localparam int F       = FRACTION_BITS;
  localparam int BCW_RAW = $clog2((MAX_WIDTH + 1) / 2);
  localparam int BRW_RAW = $clog2((MAX_HEIGHT + 1) / 2);
  localparam int BCW     = (BCW_RAW < 1) ? 1 : BCW_RAW;
  localparam int BRW     = (BRW_RAW < 1) ? 1 : BRW_RAW;
  localparam int BAW     = BCW + BRW;
  localparam int BANK_DEPTH = 1 << BAW;
  localparam int IX_W    = 13;
  localparam int LW      = 20;
  localparam int TW      = PIX_W + F;
  localparam int SW      = PIX_W + 2 * F;
  localparam int GW      = PIX_W + F + 2;

  localparam logic [F:0]               FRAC_ONE = {1'b1, {F{1'b0}}};
  localparam logic [SW:0]              IHALF    = (SW + 1)'(1) << (2 * F - 1);
  localparam logic signed [GW:0]       GHALF    = (GW + 1)'(1) << (F - 1);

  // configuration
  logic [CFG_W-1:0] img_w_r, img_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= IMG_DIM_RST;
      img_h_r <= IMG_DIM_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  img_w_r <= cfg_wdata;
        REG_IMAGE_HEIGHT: img_h_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [IX_W-1:0] w_lim, h_lim;

  always_comb begin
    w_lim = IX_W'(img_w_r);
    if (w_lim < IX_W'(2)) w_lim = IX_W'(2);
    else if (w_lim > IX_W'(MAX_WIDTH)) w_lim = IX_W'(MAX_WIDTH);
    h_lim = IX_W'(img_h_r);
    if (h_lim < IX_W'(2)) h_lim = IX_W'(2);
    else if (h_lim > IX_W'(MAX_HEIGHT)) h_lim = IX_W'(MAX_HEIGHT);
  end

  // handshake
  logic s1_vld_r, s2_vld_r, out_vld_r;
  logic rdy1, rdy2, rdy3;
  logic in_fire, is_sample, s1_load;

  assign rdy3      = !out_vld_r || out_tready;
  assign rdy2      = !s2_vld_r || rdy3;
  assign rdy1      = !s1_vld_r || rdy2;
  assign in_tready = rdy1;
  assign in_fire   = in_tvalid && in_tready;
  assign is_sample = (in_tuser == OP_SAMPLE);
  assign s1_load   = in_fire && is_sample;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (rdy1) s1_vld_r  <= s1_load;
      if (rdy2) s2_vld_r  <= s1_vld_r;
      if (rdy3) out_vld_r <= s2_vld_r;
    end
  end

  // request fields
  logic [IDX_W-1:0]          in_col, in_row;
  logic [PIX_W-1:0]          in_val;
  logic signed [COORD_W-1:0] in_u, in_v;

  assign in_col = in_tdata[COL_LSB +: IDX_W];
  assign in_row = in_tdata[ROW_LSB +: IDX_W];
  assign in_val = in_tdata[VAL_LSB +: PIX_W];
  assign in_u   = $signed(in_tdata[U_LSB +: COORD_W]);
  assign in_v   = $signed(in_tdata[V_LSB +: COORD_W]);

  // coordinate decode and border tests
  logic signed [LW-1:0] u0, v0, u1, v1, wm2, hm2;
  logic [F-1:0]         fu, fv;
  logic                 iin_c, gin_c;

  assign u0  = LW'(in_u >>> F);
  assign v0  = LW'(in_v >>> F);
  assign u1  = u0 + 20'sd1;
  assign v1  = v0 + 20'sd1;
  assign fu  = in_u[F-1:0];
  assign fv  = in_v[F-1:0];
  assign wm2 = $signed({{(LW - IX_W){1'b0}}, w_lim}) - 20'sd2;
  assign hm2 = $signed({{(LW - IX_W){1'b0}}, h_lim}) - 20'sd2;

  assign iin_c = (u0 >= 20'sd0) && (u0 <= wm2) && (v0 >= 20'sd0) && (v0 <= hm2);
  assign gin_c = (u0 >= 20'sd1) && ((u0 < wm2) || ((u0 == wm2) && (fu == '0)))
              && (v0 >= 20'sd1) && ((v0 < hm2) || ((v0 == hm2) && (fv == '0)));

  // write decode
  logic [IX_W-1:0] col_e, row_e;
  logic [1:0]      wr_bank;
  logic [BAW-1:0]  wr_addr;
  logic            wr_ok;

  assign col_e   = IX_W'(in_col);
  assign row_e   = IX_W'(in_row);
  assign wr_bank = {in_row[0], in_col[0]};
  assign wr_addr = {row_e[BRW:1], col_e[BCW:1]};
  assign wr_ok   = in_fire && (in_tuser == OP_WRITE)
                && (col_e < IX_W'(MAX_WIDTH)) && (row_e < IX_W'(MAX_HEIGHT));

  // pixel banks, index {row parity, column parity}
  wire [PIX_W-1:0] bank_q [4];

  for (genvar g = 0; g < 4; g++) begin : g_bank
    localparam logic PC = 1'(g % 2);
    localparam logic PR = 1'(g / 2);
    logic [PIX_W-1:0] mem [BANK_DEPTH];
    logic [PIX_W-1:0] q_r;
    logic [LW-1:0]    cs, rs;
    logic [BAW-1:0]   rd_addr;

    assign cs      = (u0[0] == PC) ? u0 : u1;
    assign rs      = (v0[0] == PR) ? v0 : v1;
    assign rd_addr = {rs[BRW:1], cs[BCW:1]};

    always_ff @(posedge clk) begin
      if (wr_ok && (wr_bank == 2'(g))) mem[wr_addr] <= in_val;
      if (s1_load) q_r <= mem[rd_addr];
    end

    assign bank_q[g] = q_r;
  end

  // stage 1: bank read data plus request info
  logic [F-1:0] s1_fu_r, s1_fv_r;
  logic         s1_up_r, s1_vp_r, s1_iin_r, s1_gin_r;

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_fu_r  <= fu;
      s1_fv_r  <= fv;
      s1_up_r  <= u0[0];
      s1_vp_r  <= v0[0];
      s1_iin_r <= iin_c;
      s1_gin_r <= gin_c;
    end
  end

  logic [PIX_W-1:0]     pa, pb, pc, pd;
  logic [F:0]           ou1, ov1;
  logic signed [PIX_W:0] dba, ddc, dca, ddb;
  logic signed [GW-1:0]  ous, ovs, fus, fvs;
  logic [TW-1:0]         top_nxt, bot_nxt;
  logic signed [GW-1:0]  su_nxt, sv_nxt;

  assign pa  = bank_q[{s1_vp_r, s1_up_r}];
  assign pb  = bank_q[{s1_vp_r, ~s1_up_r}];
  assign pc  = bank_q[{~s1_vp_r, s1_up_r}];
  assign pd  = bank_q[{~s1_vp_r, ~s1_up_r}];
  assign ou1 = FRAC_ONE - {1'b0, s1_fu_r};
  assign ov1 = FRAC_ONE - {1'b0, s1_fv_r};

  assign dba = $signed({1'b0, pb}) - $signed({1'b0, pa});
  assign ddc = $signed({1'b0, pd}) - $signed({1'b0, pc});
  assign dca = $signed({1'b0, pc}) - $signed({1'b0, pa});
  assign ddb = $signed({1'b0, pd}) - $signed({1'b0, pb});
  assign ous = $signed(GW'(ou1));
  assign ovs = $signed(GW'(ov1));
  assign fus = $signed(GW'(s1_fu_r));
  assign fvs = $signed(GW'(s1_fv_r));

  assign top_nxt = TW'(pa) * TW'(ou1) + TW'(pb) * TW'(s1_fu_r);
  assign bot_nxt = TW'(pc) * TW'(ou1) + TW'(pd) * TW'(s1_fu_r);
  assign su_nxt  = GW'(dba) * ovs + GW'(ddc) * fvs;
  assign sv_nxt  = GW'(dca) * ous + GW'(ddb) * fus;

  // stage 2: horizontal blends and raw gradients
  logic [TW-1:0]        s2_top_r, s2_bot_r;
  logic signed [GW-1:0] s2_su_r, s2_sv_r;
  logic [F-1:0]         s2_fv_r;
  logic                 s2_iin_r, s2_gin_r;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_top_r <= top_nxt;
      s2_bot_r <= bot_nxt;
      s2_su_r  <= su_nxt;
      s2_sv_r  <= sv_nxt;
      s2_fv_r  <= s1_fv_r;
      s2_iin_r <= s1_iin_r;
      s2_gin_r <= s1_gin_r;
    end
  end

  logic [F:0]            ov2;
  logic [SW-1:0]         sacc;
  logic [SW:0]           irnd;
  logic [PIX_W:0]        iq;
  logic [PIX_W-1:0]      int_nxt;
  logic signed [GW:0]    gu_sum, gv_sum;
  logic [GRAD_W-1:0]     gu_nxt, gv_nxt;

  assign ov2     = FRAC_ONE - {1'b0, s2_fv_r};
  assign sacc    = SW'(s2_top_r) * SW'(ov2) + SW'(s2_bot_r) * SW'(s2_fv_r);
  assign irnd    = {1'b0, sacc} + IHALF;
  assign iq      = irnd[SW:2*F];
  assign int_nxt = !s2_iin_r ? '0 : (iq[PIX_W] ? '1 : iq[PIX_W-1:0]);
  assign gu_sum  = (GW + 1)'(s2_su_r) + GHALF;
  assign gv_sum  = (GW + 1)'(s2_sv_r) + GHALF;
  assign gu_nxt  = s2_gin_r ? gu_sum[F +: GRAD_W] : '0;
  assign gv_nxt  = s2_gin_r ? gv_sum[F +: GRAD_W] : '0;

  // stage 3: output register
  logic [PIX_W-1:0]  out_int_r;
  logic [GRAD_W-1:0] out_gu_r, out_gv_r;
  logic              out_iin_r, out_gin_r;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      out_int_r <= int_nxt;
      out_gu_r  <= gu_nxt;
      out_gv_r  <= gv_nxt;
      out_iin_r <= s2_iin_r;
      out_gin_r <= s2_gin_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_gv_r, out_gu_r, out_int_r};
  assign out_tuser  = {out_gin_r, out_iin_r};

  // checks
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> s1_vld_r)
    else $error("input stalled with stage 1 empty");

  a_sample_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == OP_SAMPLE) |=> s1_vld_r)
    else $error("accepted sample request lost");

  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> (out_tdata[INT_LSB +: PIX_W] == '0) && !out_tuser[1])
    else $error("intensity not zero outside image");

  a_border_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[1] |->
      (out_tdata[GU_LSB +: GRAD_W] == '0) && (out_tdata[GV_LSB +: GRAD_W] == '0))
    else $error("gradient not zero near border");

endmodule
